### design/slu_pkg.sv
// shared types and constants for the string literal unescaper
// no dependencies; used by the channel interfaces and the core
`default_nettype none

package slu_pkg;

   // result queue sizing
   localparam int QUEUE_DEPTH = 3;
   localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

   // special source bytes
   localparam logic [7:0] QUOTE_BYTE     = 8'h22;
   localparam logic [7:0] BACKSLASH_BYTE = 8'h5C;
   localparam logic [7:0] CHAR_0         = 8'h30;
   localparam logic [7:0] CHAR_1         = 8'h31;
   localparam logic [7:0] CHAR_7         = 8'h37;
   localparam logic [7:0] CHAR_9         = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F   = 8'h46;
   localparam logic [7:0] CHAR_LOWER_A   = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F   = 8'h66;
   localparam logic [7:0] CHAR_UPPER_X   = 8'h58;
   localparam logic [7:0] CHAR_LOWER_X   = 8'h78;

   // parser state
   typedef enum logic [2:0] {
      MODE_WAIT = 3'd0,
      MODE_BODY = 3'd1,
      MODE_ESC  = 3'd2,
      MODE_HEX1 = 3'd3,
      MODE_HEX2 = 3'd4,
      MODE_OCT  = 3'd5
   } slu_mode_type;

   // result kinds
   typedef enum logic [1:0] {
      KIND_DATA    = 2'd0,
      KIND_DONE    = 2'd1,
      KIND_NOPARSE = 2'd2,
      KIND_ERROR   = 2'd3
   } slu_kind_type;

   // input beat
   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_input;
   } slu_req_type;

   // result beat
   typedef struct packed {
      logic [7:0]   out_byte;
      slu_kind_type kind;
      logic         last;
   } slu_rsp_type;

endpackage

`default_nettype wire

### design/slu_req_if.sv
// valid/ready channel carrying source bytes into the unescaper
// depends on slu_pkg for the beat type
`default_nettype none

interface slu_req_if;
   import slu_pkg::*;

   logic        valid;
   logic        ready;
   slu_req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### design/slu_rsp_if.sv
// valid/ready channel carrying decoded results out of the unescaper
// depends on slu_pkg for the beat type
`default_nettype none

interface slu_rsp_if;
   import slu_pkg::*;

   logic        valid;
   logic        ready;
   slu_rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### design/string_literal_unescaper_core.sv
// Decodes a byte stream of double-quoted literals with C style escapes.
// Each accepted source beat is decoded in the same cycle it is taken and
// produces zero, one or two result beats, which go into a three-entry result
// queue; the head of that queue drives the result channel. A source beat is
// taken whenever at most one result is waiting, so with a sink that takes a
// result every cycle the block runs at one byte per clock, except that a byte
// that closes a hex or octal run and also yields a body result puts two results
// in the queue, which holds off the next source beat; the queue depth sets this limit.
// Results are registered in the queue and come out in the next cycle at the earliest.
// depends on slu_pkg, slu_req_if and slu_rsp_if
`default_nettype none

module string_literal_unescaper_core (
   input wire logic  clock,
   input wire logic  reset,
   slu_req_if.sink   req_bus,
   slu_rsp_if.source rsp_bus
);
   import slu_pkg::*;

   slu_mode_type           mode_ff, mode_in;
   logic [3:0]             digit_ff, digit_in;
   slu_rsp_type            slot_ff [QUEUE_DEPTH];
   slu_rsp_type            slot_in [QUEUE_DEPTH];
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [COUNT_W-1:0]     count_after_pop;

   logic                   req_fire, rsp_fire;
   logic [7:0]             c;
   logic                   eoi, is_quote, is_backslash, is_octal, is_esc_digit, is_x;
   logic                   hex_ok;
   logic [3:0]             hex_val;
   slu_rsp_type            body_entry;
   slu_mode_type           body_mode;
   slu_rsp_type            res0, res1;
   logic [1:0]             res_count;

   // build a result entry
   function automatic slu_rsp_type make_entry(input logic [7:0] b, input slu_kind_type k);
      slu_rsp_type e;
      e.out_byte = b;
      e.kind     = k;
      e.last     = 1'b0;
      return e;
   endfunction

   // control code for an escaped letter or 0, else the byte itself
   function automatic logic [7:0] escape_code(input logic [7:0] b);
      logic [7:0] r;
      unique case (b)
         8'h6E, 8'h4E: r = 8'h0A;  // n
         8'h74, 8'h54: r = 8'h09;  // t
         8'h72, 8'h52: r = 8'h0D;  // r
         8'h61, 8'h41: r = 8'h07;  // a
         8'h62, 8'h42: r = 8'h08;  // b
         8'h66, 8'h46: r = 8'h0C;  // f
         8'h76, 8'h56: r = 8'h0B;  // v
         CHAR_0:       r = 8'h00;
         default:      r = b;
      endcase
      return r;
   endfunction

   // handshakes
   assign req_fire        = req_bus.valid && req_bus.ready;
   assign rsp_fire        = rsp_bus.valid && rsp_bus.ready;
   assign req_bus.ready   = (count_ff <= COUNT_W'(1));
   assign rsp_bus.valid   = (count_ff != '0);
   assign rsp_bus.payload = slot_ff[0];

   // byte classification
   assign c            = req_bus.payload.in_byte;
   assign eoi          = req_bus.payload.end_of_input;
   assign is_quote     = (c == QUOTE_BYTE);
   assign is_backslash = (c == BACKSLASH_BYTE);
   assign is_octal     = (c >= CHAR_0) && (c <= CHAR_7);
   assign is_esc_digit = (c >= CHAR_1) && (c <= CHAR_7);
   assign is_x         = (c == CHAR_LOWER_X) || (c == CHAR_UPPER_X);

   // hex digit value
   always_comb begin
      hex_ok  = 1'b1;
      hex_val = 4'h0;
      if ((c >= CHAR_0) && (c <= CHAR_9)) begin
         hex_val = 4'(c - CHAR_0);
      end else if ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_F)) begin
         hex_val = 4'(c - CHAR_LOWER_A + 8'd10);
      end else if ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_F)) begin
         hex_val = 4'(c - CHAR_UPPER_A + 8'd10);
      end else begin
         hex_ok = 1'b0;
      end
   end

   // what a plain body byte does
   assign body_entry = is_quote ? make_entry(8'h00, KIND_DONE) : make_entry(c, KIND_DATA);
   assign body_mode  = is_quote ? MODE_WAIT : (is_backslash ? MODE_ESC : MODE_BODY);

   // next state of the parser
   always_comb begin
      mode_in  = mode_ff;
      digit_in = digit_ff;
      if (req_fire) begin
         unique case (mode_ff)
            MODE_BODY, MODE_ESC, MODE_HEX1, MODE_HEX2, MODE_OCT: begin
               if (eoi) begin
                  mode_in  = MODE_WAIT;
                  digit_in = 4'h0;
               end else begin
                  unique case (mode_ff)
                     MODE_BODY: mode_in = body_mode;
                     MODE_ESC: begin
                        if (is_x) begin
                           mode_in = MODE_HEX1;
                        end else if (is_esc_digit) begin
                           mode_in  = MODE_OCT;
                           digit_in = 4'(c - CHAR_0);
                        end else begin
                           mode_in = MODE_BODY;
                        end
                     end
                     MODE_HEX1: begin
                        if (hex_ok) begin
                           mode_in  = MODE_HEX2;
                           digit_in = hex_val;
                        end else begin
                           mode_in = body_mode;
                        end
                     end
                     MODE_HEX2: begin
                        mode_in  = hex_ok ? MODE_BODY : body_mode;
                        digit_in = 4'h0;
                     end
                     default: begin
                        mode_in  = is_octal ? MODE_BODY : body_mode;
                        digit_in = 4'h0;
                     end
                  endcase
               end
            end
            // waiting for the opening quote
            default: mode_in = (!eoi && is_quote) ? MODE_BODY : MODE_WAIT;
         endcase
      end
   end

   // results caused by the current beat
   always_comb begin
      res0      = make_entry(8'h00, KIND_DATA);
      res1      = make_entry(8'h00, KIND_DATA);
      res_count = 2'd0;
      unique case (mode_ff)
         MODE_BODY, MODE_ESC, MODE_HEX1, MODE_HEX2, MODE_OCT: begin
            if (eoi) begin
               res0      = make_entry(8'h00, KIND_ERROR);
               res_count = 2'd1;
            end else begin
               unique case (mode_ff)
                  MODE_BODY: begin
                     res0      = body_entry;
                     res_count = is_backslash ? 2'd0 : 2'd1;
                  end
                  MODE_ESC: begin
                     if (!is_x && !is_esc_digit) begin
                        res0      = make_entry(escape_code(c), KIND_DATA);
                        res_count = 2'd1;
                     end
                  end
                  MODE_HEX1: begin
                     if (!hex_ok) begin
                        res0      = make_entry(CHAR_LOWER_X, KIND_DATA);
                        res1      = body_entry;
                        res_count = is_backslash ? 2'd1 : 2'd2;
                     end
                  end
                  MODE_HEX2: begin
                     if (hex_ok) begin
                        res0      = make_entry({digit_ff, hex_val}, KIND_DATA);
                        res_count = 2'd1;
                     end else begin
                        res0      = make_entry({4'h0, digit_ff}, KIND_DATA);
                        res1      = body_entry;
                        res_count = is_backslash ? 2'd1 : 2'd2;
                     end
                  end
                  default: begin
                     if (is_octal) begin
                        res0      = make_entry({2'b00, digit_ff[2:0], c[2:0]}, KIND_DATA);
                        res_count = 2'd1;
                     end else begin
                        res0      = make_entry({5'b00000, digit_ff[2:0]}, KIND_DATA);
                        res1      = body_entry;
                        res_count = is_backslash ? 2'd1 : 2'd2;
                     end
                  end
               endcase
            end
         end
         // waiting for the opening quote
         default: begin
            if (eoi || !is_quote) begin
               res0      = make_entry(8'h00, KIND_NOPARSE);
               res_count = 2'd1;
            end
         end
      endcase
      // flag the final result of the beat
      if (res_count == 2'd1) begin
         res0.last = 1'b1;
      end
      if (res_count == 2'd2) begin
         res1.last = 1'b1;
      end
   end

   // result queue: shift out at the head, append behind the survivors
   assign count_after_pop = count_ff - COUNT_W'(rsp_fire);
   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (rsp_fire && (i < QUEUE_DEPTH - 1)) begin
            slot_in[i] = slot_ff[i + 1];
         end else begin
            slot_in[i] = slot_ff[i];
         end
         if (req_fire && (res_count != 2'd0) && (COUNT_W'(i) == count_after_pop)) begin
            slot_in[i] = res0;
         end
         if (req_fire && (res_count == 2'd2)
             && (COUNT_W'(i) == count_after_pop + COUNT_W'(1))) begin
            slot_in[i] = res1;
         end
      end
      count_in = count_after_pop + (req_fire ? COUNT_W'(res_count) : COUNT_W'(0));
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_WAIT;
         digit_ff <= 4'h0;
         count_ff <= '0;
      end else begin
         mode_ff  <= mode_in;
         digit_ff <= digit_in;
         count_ff <= count_in;
      end
   end

   // queue payload
   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   // queue occupancy follows pushes and pops
   assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> count_ff == $past(count_ff) - COUNT_W'($past(rsp_fire))
               + ($past(req_fire) ? COUNT_W'($past(res_count)) : COUNT_W'(0)))
      else $error("result queue count out of step");

   // end of input inside a literal returns to waiting with no pending digit
   assert property (@(posedge clock) disable iff (reset)
      req_fire && req_bus.payload.end_of_input && (mode_ff != MODE_WAIT)
      |=> (mode_ff == MODE_WAIT) && (digit_ff == 4'h0))
      else $error("parser not reset after unexpected end");

   // a beat making two results marks only the second as last
   assert property (@(posedge clock) disable iff (reset)
      req_fire && (res_count == 2'd2) |-> !res0.last && res1.last && (res0.kind == KIND_DATA))
      else $error("two-result beat badly flagged");

   // non-data results carry a zero byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && (rsp_bus.payload.kind != KIND_DATA) |-> rsp_bus.payload.out_byte == 8'h00)
      else $error("non-data result with nonzero byte");

   // the queue never overflows
   assert property (@(posedge clock) disable iff (reset)
      req_fire |-> ({1'b0, count_after_pop} + {1'b0, COUNT_W'(res_count)})
                   <= (COUNT_W + 1)'(QUEUE_DEPTH))
      else $error("result queue overflow");

endmodule

`default_nettype wire
